[rtl/quad_x_motor_mixer_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the X-layout motor mixer
// Shared concurrent assertion forms, clocked on clk, off while in reset.
// ---------------------------------------------------------------------------
`ifndef QUAD_X_MOTOR_MIXER_MACROS_SVH
`define QUAD_X_MOTOR_MIXER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QXMM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QXMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/qxmm_pkg.sv]
// ---------------------------------------------------------------------------
// qxmm_pkg
// Shared widths, register indexes, reset values and mix signs for the mixer.
// ---------------------------------------------------------------------------
package qxmm_pkg;

  localparam int CMD_W      = 12;  // throttle, stick, limits, motor commands
  localparam int CORR_W     = 13;  // signed roll / pitch / yaw corrections
  localparam int SUM_W      = 16;  // signed mix sums and shifted values
  localparam int NUM_MOTORS = 4;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic signed [CORR_W-1:0] corr_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_THROTTLE = 2'd0,
    REG_MIN_THROTTLE = 2'd1,
    REG_MIN_CHECK    = 2'd2,
    REG_MIN_COMMAND  = 2'd3
  } reg_idx_t;

  localparam cmd_t RST_MAX_THROTTLE = 12'd1850;
  localparam cmd_t RST_MIN_THROTTLE = 12'd1150;
  localparam cmd_t RST_MIN_CHECK    = 12'd1100;
  localparam cmd_t RST_MIN_COMMAND  = 12'd1000;

  // Limits handed from the register bank to the mixing logic
  typedef struct packed {
    cmd_t max_throttle;
    cmd_t min_throttle;
    cmd_t min_check;
    cmd_t min_command;
  } limits_t;

  // Motor order: front left, front right, rear right, rear left
  localparam int MOTOR_FL = 0;
  localparam int MOTOR_FR = 1;
  localparam int MOTOR_RR = 2;
  localparam int MOTOR_RL = 3;

  typedef cmd_t motor_vec_t [NUM_MOTORS];

  // A set bit subtracts that correction instead of adding it
  typedef struct packed {
    logic neg_roll;
    logic neg_pitch;
    logic neg_yaw;
  } mix_sign_t;

  localparam mix_sign_t MIX_TABLE [NUM_MOTORS] = '{
    '{neg_roll: 1'b0, neg_pitch: 1'b1, neg_yaw: 1'b1},  // front left
    '{neg_roll: 1'b1, neg_pitch: 1'b1, neg_yaw: 1'b0},  // front right
    '{neg_roll: 1'b1, neg_pitch: 1'b0, neg_yaw: 1'b1},  // rear right
    '{neg_roll: 1'b0, neg_pitch: 1'b0, neg_yaw: 1'b0}   // rear left
  };

endpackage

[rtl/quad_x_motor_mixer.sv]
// ---------------------------------------------------------------------------
// quad_x_motor_mixer: X-layout motor mixer, input stage then result register.
// Throughput: one request per cycle; the mix sits between two registers.
// Stalls only while the result register holds a request not yet taken.
// Reset: synchronous, active low; empties both stages, limits to defaults.
// ---------------------------------------------------------------------------
`include "quad_x_motor_mixer_macros.svh"

module quad_x_motor_mixer (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  qxmm_pkg::cfg_idx_t     cfg_index,
  input  qxmm_pkg::cmd_t         cfg_wdata,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  qxmm_pkg::cmd_t         in_throttle_command,
  input  qxmm_pkg::corr_t        in_roll_correction,
  input  qxmm_pkg::corr_t        in_pitch_correction,
  input  qxmm_pkg::corr_t        in_yaw_correction,
  input  qxmm_pkg::cmd_t         in_throttle_stick,
  input  logic                   in_armed,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output qxmm_pkg::cmd_t         out_motor_front_left,
  output qxmm_pkg::cmd_t         out_motor_front_right,
  output qxmm_pkg::cmd_t         out_motor_rear_right,
  output qxmm_pkg::cmd_t         out_motor_rear_left
);
  import qxmm_pkg::*;

  // Limit registers
  cmd_t    max_throttle_r, max_throttle_nxt;
  cmd_t    min_throttle_r, min_throttle_nxt;
  cmd_t    min_check_r,    min_check_nxt;
  cmd_t    min_command_r,  min_command_nxt;
  limits_t limits;

  // Input stage
  logic    s1_valid_r, s1_valid_nxt;
  cmd_t    s1_thr_r;
  corr_t   s1_roll_r;
  corr_t   s1_pitch_r;
  corr_t   s1_yaw_r;
  cmd_t    s1_stick_r;
  logic    s1_armed_r;

  // Result stage
  logic       out_valid_r, out_valid_nxt;
  motor_vec_t out_motor_r;
  motor_vec_t mix_motor;

  logic in_take;
  logic out_load;

  // ------------------------------------------------------------------
  // Configuration: decode the index, drop writes to nothing else
  // ------------------------------------------------------------------
  always_comb begin
    max_throttle_nxt = max_throttle_r;
    min_throttle_nxt = min_throttle_r;
    min_check_nxt    = min_check_r;
    min_command_nxt  = min_command_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MAX_THROTTLE: max_throttle_nxt = cfg_wdata;
        REG_MIN_THROTTLE: min_throttle_nxt = cfg_wdata;
        REG_MIN_CHECK:    min_check_nxt    = cfg_wdata;
        REG_MIN_COMMAND:  min_command_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_throttle_r <= RST_MAX_THROTTLE;
      min_throttle_r <= RST_MIN_THROTTLE;
      min_check_r    <= RST_MIN_CHECK;
      min_command_r  <= RST_MIN_COMMAND;
    end else begin
      max_throttle_r <= max_throttle_nxt;
      min_throttle_r <= min_throttle_nxt;
      min_check_r    <= min_check_nxt;
      min_command_r  <= min_command_nxt;
    end
  end

  assign limits = '{max_throttle: max_throttle_r,
                    min_throttle: min_throttle_r,
                    min_check:    min_check_r,
                    min_command:  min_command_r};

  // ------------------------------------------------------------------
  // Pipeline control: the result register loads whenever it is empty or
  // being drained; the input stage advances in the same cycle, so a new
  // request can enter while the previous result waits to be taken.
  // ------------------------------------------------------------------
  assign out_load = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_load;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    // hold unless the stage moves on or refills
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input payload: capture on accept
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_thr_r   <= in_throttle_command;
      s1_roll_r  <= in_roll_correction;
      s1_pitch_r <= in_pitch_correction;
      s1_yaw_r   <= in_yaw_correction;
      s1_stick_r <= in_throttle_stick;
      s1_armed_r <= in_armed;
    end
  end

  // ------------------------------------------------------------------
  // Mix, peak shift, clamp and overrides
  // ------------------------------------------------------------------
  qxmm_mix u_mix (
    .throttle_command (s1_thr_r),
    .roll_correction  (s1_roll_r),
    .pitch_correction (s1_pitch_r),
    .yaw_correction   (s1_yaw_r),
    .throttle_stick   (s1_stick_r),
    .armed            (s1_armed_r),
    .limits           (limits),
    .motor            (mix_motor)
  );

  // Result payload: load only when a request moves into the register
  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_motor_r <= mix_motor;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_motor_front_left  = out_motor_r[MOTOR_FL];
  assign out_motor_front_right = out_motor_r[MOTOR_FR];
  assign out_motor_rear_right  = out_motor_r[MOTOR_RR];
  assign out_motor_rear_left   = out_motor_r[MOTOR_RL];

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `QXMM_ASSERT_NEXT(a_stage_hold, s1_valid_r && !out_load && !in_take,
    s1_valid_r, "input stage dropped a request while stalled")
  `QXMM_ASSERT_NEXT(a_disarmed_idle, s1_valid_r && out_load && !s1_armed_r,
    out_valid_r && out_motor_front_left == min_command_r &&
    out_motor_rear_left == min_command_r, "disarmed request not at idle command")
  `QXMM_ASSERT_NEXT(a_clamp_range,
    s1_valid_r && out_load && s1_armed_r && s1_stick_r >= min_check_r &&
    min_throttle_r <= max_throttle_r,
    out_motor_front_right <= max_throttle_r &&
    out_motor_front_right >= min_throttle_r, "armed motor command out of range")
  `QXMM_ASSERT_SAME(a_ready_when_free, !s1_valid_r, in_ready,
    "input stage empty but request refused")

endmodule

[rtl/qxmm_mix.sv]
// ---------------------------------------------------------------------------
// qxmm_mix
// Combinational X-layout mix: sums, peak shift, clamp and overrides.
// ---------------------------------------------------------------------------
module qxmm_mix (
  input  qxmm_pkg::cmd_t      throttle_command,
  input  qxmm_pkg::corr_t     roll_correction,
  input  qxmm_pkg::corr_t     pitch_correction,
  input  qxmm_pkg::corr_t     yaw_correction,
  input  qxmm_pkg::cmd_t      throttle_stick,
  input  logic                armed,
  input  qxmm_pkg::limits_t   limits,
  output qxmm_pkg::motor_vec_t motor
);
  import qxmm_pkg::*;

  sum_t mix     [NUM_MOTORS];
  sum_t peak_a;
  sum_t peak_b;
  sum_t peak;
  sum_t hi;
  sum_t lo;
  sum_t excess;
  sum_t shifted;
  sum_t clamped;
  sum_t thr_s;
  sum_t roll_s;
  sum_t pitch_s;
  sum_t yaw_s;
  logic over;

  always_comb begin
    thr_s   = sum_t'({4'b0, throttle_command});
    roll_s  = SUM_W'(roll_correction);
    pitch_s = SUM_W'(pitch_correction);
    yaw_s   = SUM_W'(yaw_correction);
    hi      = sum_t'({4'b0, limits.max_throttle});
    lo      = sum_t'({4'b0, limits.min_throttle});

    for (int k = 0; k < NUM_MOTORS; k++) begin
      mix[k] = thr_s
             + (MIX_TABLE[k].neg_roll  ? -roll_s  : roll_s)
             + (MIX_TABLE[k].neg_pitch ? -pitch_s : pitch_s)
             + (MIX_TABLE[k].neg_yaw   ? -yaw_s   : yaw_s);
    end

    // Peak of four as a two-level compare tree
    peak_a = (mix[1] > mix[0]) ? mix[1] : mix[0];
    peak_b = (mix[3] > mix[2]) ? mix[3] : mix[2];
    peak   = (peak_b > peak_a) ? peak_b : peak_a;
    over   = (peak > hi);
    excess = over ? (peak - hi) : '0;

    for (int k = 0; k < NUM_MOTORS; k++) begin
      shifted = mix[k] - excess;
      // Low bound checked first: crossed limits resolve to min throttle
      if (shifted < lo) begin
        clamped = lo;
      end else if (shifted > hi) begin
        clamped = hi;
      end else begin
        clamped = shifted;
      end
      if (throttle_stick < limits.min_check) begin
        clamped = lo;
      end
      if (!armed) begin
        motor[k] = limits.min_command;
      end else begin
        motor[k] = clamped[CMD_W-1:0];
      end
    end
  end

endmodule
